FILE: rtl/ir_distance_average_linearizer_assert.svh
// Assertion macros shared by the linearizer RTL files.
// Uses the clk and rst_n names of the module that includes it.
`ifndef IR_DISTANCE_AVERAGE_LINEARIZER_ASSERT_SVH
`define IR_DISTANCE_AVERAGE_LINEARIZER_ASSERT_SVH
`ifndef SYNTH
`define IRDAL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("irdal assertion failed");
`define IRDAL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("irdal assertion failed");
`else
`define IRDAL_ASSERT(lbl, prop)
`define IRDAL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/irdal_pkg.sv
// Types, breakpoint tables and helpers of the IR distance linearizer.
// No dependencies; imported by every module of the block.
`default_nettype none
package irdal_pkg;
    localparam int ADC_BITS_DEF = 10;
    localparam int SUM_W        = 16;
    localparam int CNT_W        = 6;
    localparam int DIST_W       = 7;
    localparam int MEAN_W       = 10;
    localparam int DVS_W        = 12;
    localparam int D_W          = 8;
    localparam int NUM_BP       = 8;
    localparam int SEG_W        = 3;

    localparam logic [CNT_W-1:0] COUNT_RESET = 6'd20;
    localparam logic [SUM_W-1:0] SLOPE_SCALE = 16'd100;
    localparam logic [SEG_W-1:0] SEG_HALF    = 3'd2;

    localparam logic [SUM_W-1:0] BP_POS [NUM_BP] = '{
        16'd80, 16'd87, 16'd106, 16'd124, 16'd150, 16'd196, 16'd276, 16'd490
    };
    localparam logic [DIST_W-1:0] BP_VAL [NUM_BP] = '{
        7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10
    };
    localparam logic [DVS_W-1:0] SEG_DIV [NUM_BP-1] = '{
        12'd77, 12'd211, 12'd0, 12'd288, 12'd511, 12'd888, 12'd2377
    };

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } grp_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [DIST_W-1:0] sub_floor(input logic [DIST_W-1:0] base,
                                                    input logic [SUM_W-1:0]  step);
        return (step <= SUM_W'(base)) ? base - DIST_W'(step) : '0;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/irdal_front.sv
// Front end: accepts samples, accumulates each group, posts group sums.
// Depends on irdal_pkg.
`default_nettype none
module irdal_front #(
    parameter int ADC_BITS = irdal_pkg::ADC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [ADC_BITS-1:0]         adc_sample,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [irdal_pkg::CNT_W-1:0] cfg_data,
    output logic                             q_push,
    output irdal_pkg::grp_t                  q_data,
    input  wire logic                        q_full
);
    import irdal_pkg::*;

    logic [CNT_W-1:0] sample_count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] taken_reg;
    logic [CNT_W-1:0] count;
    logic [CNT_W:0]   taken_inc;
    logic [SUM_W-1:0] sum_add;
    logic             accept;
    logic             last;

    assign full      = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;
    assign count     = (sample_count_reg == '0) ? CNT_W'(1) : sample_count_reg;
    assign taken_inc = {1'b0, taken_reg} + (CNT_W+1)'(1);
    assign last      = taken_inc >= {1'b0, count};
    assign sum_add   = sum_reg + SUM_W'(adc_sample);
    assign q_push    = accept && last;
    assign q_data    = '{sum: sum_add, count: count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= COUNT_RESET;
            sum_reg          <= '0;
            taken_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sample_count_reg <= cfg_data;
            end
            if (accept)
            begin
                if (last)
                begin
                    sum_reg   <= '0;
                    taken_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_add;
                    taken_reg <= taken_inc[CNT_W-1:0];
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/irdal_fifo.sv
// Two-entry queue of group sums between front and back end.
// Depends on irdal_pkg and the assertion header.
`default_nettype none
`include "ir_distance_average_linearizer_assert.svh"
module irdal_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire irdal_pkg::grp_t  wr_data,
    output logic                  full,
    input  wire logic             pop,
    output irdal_pkg::grp_t       rd_data,
    output logic                  empty
);
    import irdal_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    grp_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = cnt_reg == (PTR_W+1)'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + (PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - (PTR_W+1)'(1);
            end
        end
    end

    `IRDAL_ASSERT(a_no_push_when_full, push |-> !full)
    `IRDAL_ASSERT(a_cnt_bound, cnt_reg <= (PTR_W+1)'(DEPTH))
endmodule
`default_nettype wire

FILE: rtl/irdal_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on irdal_pkg and the assertion header.
`default_nettype none
`include "ir_distance_average_linearizer_assert.svh"
module irdal_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire irdal_pkg::div_req_t req,
    output irdal_pkg::div_rsp_t      rsp
);
    import irdal_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign rsp    = '{busy: busy_reg, done: done_reg, quotient: quo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(SUM_W - 1));
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
        end
    end

    `IRDAL_ASSERT(a_no_restart, req.start |-> !busy_reg)
endmodule
`default_nettype wire

FILE: rtl/irdal_back.sv
// Back end: divides each group sum, classifies the mean against the
// breakpoint table, finishes the slope step and holds the result beat.
// Depends on irdal_pkg and the assertion header.
`default_nettype none
`include "ir_distance_average_linearizer_assert.svh"
module irdal_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire irdal_pkg::grp_t              q_data,
    output logic                              q_pop,
    output irdal_pkg::div_req_t               div_req,
    input  wire irdal_pkg::div_rsp_t          div_rsp,
    input  wire logic                         pop,
    output logic                              empty,
    output logic [irdal_pkg::DIST_W-1:0]      distance_cm,
    output logic [irdal_pkg::MEAN_W-1:0]      mean_value,
    output logic                              out_of_range
);
    import irdal_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV1  = 6'b000010,
        S_CLASS = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV2  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SUM_W-1:0]  mean_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic [D_W-1:0]    d_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              held_reg;
    logic [DIST_W-1:0] last_dist_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [SUM_W-1:0]  out_mean_reg;
    logic              out_oor_reg;

    logic              le_lo;
    logic              gt_hi;
    logic              hit;
    logic [DIST_W-1:0] hit_val;
    logic [SEG_W-1:0]  seg;
    logic [SUM_W-1:0]  d_full;
    logic [D_W-1:0]    d;
    logic [SUM_W-1:0]  num;
    logic              out_free;
    logic              load_out;

    assign empty        = !out_valid_reg;
    assign distance_cm  = out_dist_reg;
    assign mean_value   = MEAN_W'(out_mean_reg);
    assign out_of_range = out_oor_reg;
    assign out_free     = !out_valid_reg || pop;
    assign load_out     = (state_reg == S_OUT) && out_free;
    assign q_pop        = (state_reg == S_IDLE) && !q_empty;

    assign num = SUM_W'(SUM_W'(d_reg) * SLOPE_SCALE + SUM_W'(SEG_DIV[seg_reg]) - SUM_W'(1));

    always_comb
    begin
        div_req.start    = q_pop || (state_reg == S_MUL);
        div_req.dividend = (state_reg == S_MUL) ? num : q_data.sum;
        div_req.divisor  = (state_reg == S_MUL) ? SEG_DIV[seg_reg] : DVS_W'(q_data.count);
    end

    always_comb
    begin
        le_lo   = mean_reg <= BP_POS[0];
        gt_hi   = mean_reg > BP_POS[NUM_BP-1];
        hit     = 1'b0;
        hit_val = '0;
        seg     = '0;
        for (int i = 1; i < NUM_BP; i++)
        begin
            if (mean_reg == BP_POS[i])
            begin
                hit     = 1'b1;
                hit_val = BP_VAL[i];
            end
        end
        for (int i = 0; i < NUM_BP - 1; i++)
        begin
            if (mean_reg > BP_POS[i] && mean_reg < BP_POS[i+1])
            begin
                seg = SEG_W'(i);
            end
        end
        d_full = mean_reg - BP_POS[seg];
        d      = D_W'(d_full);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (le_lo || gt_hi || hit || seg == SEG_HALF)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_dist_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                last_dist_reg <= dist_reg;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV1 && div_rsp.done)
        begin
            mean_reg <= div_rsp.quotient;
        end
        if (state_reg == S_CLASS)
        begin
            held_reg <= gt_hi;
            seg_reg  <= seg;
            d_reg    <= d;
            priority if (le_lo)
            begin
                dist_reg <= BP_VAL[0];
            end
            else if (gt_hi)
            begin
                dist_reg <= last_dist_reg;
            end
            else if (hit)
            begin
                dist_reg <= hit_val;
            end
            else
            begin
                dist_reg <= sub_floor(BP_VAL[seg], SUM_W'(d >> 1));
            end
        end
        if (state_reg == S_DIV2 && div_rsp.done)
        begin
            dist_reg <= sub_floor(BP_VAL[seg_reg], div_rsp.quotient);
        end
        if (load_out)
        begin
            out_dist_reg <= dist_reg;
            out_mean_reg <= mean_reg;
            out_oor_reg  <= held_reg;
        end
    end

    `IRDAL_ASSERT(a_load_from_out, $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
    `IRDAL_ASSERT(a_dist_bound, out_valid_reg |-> out_dist_reg <= BP_VAL[0])
endmodule
`default_nettype wire

FILE: rtl/ir_distance_average_linearizer.sv
// Top level of the IR distance averaging linearizer.
// Depends on irdal_pkg, irdal_front, irdal_fifo, irdal_div, irdal_back.
//
// Channel   Handshake            Payload
// input     push / full          adc_sample
// config    cfg_valid/cfg_ready  cfg_data (sample_count)
// result    empty / pop          distance_cm, mean_value, out_of_range
//
// A sample is taken in any cycle in which the queue is not full; a group end posts its sum to a 2-deep queue.
// Each result takes one 16-step divide of the group sum by the count, and a
// second 16-step divide for a sloped segment.
// rst_n clears sums, counts, held distance, queue and output; count resets to 20.
// The front stalls only on a full queue; the back stalls only on an untaken result.
`default_nettype none
module ir_distance_average_linearizer #(
    parameter int ADC_BITS = irdal_pkg::ADC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [ADC_BITS-1:0]          adc_sample,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [irdal_pkg::CNT_W-1:0]  cfg_data,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [irdal_pkg::DIST_W-1:0]      distance_cm,
    output logic [irdal_pkg::MEAN_W-1:0]      mean_value,
    output logic                              out_of_range
);
    import irdal_pkg::*;

    logic     q_push;
    grp_t     q_wr_data;
    logic     q_full;
    logic     q_pop;
    grp_t     q_rd_data;
    logic     q_empty;
    div_req_t div_req;
    div_rsp_t div_rsp;

    irdal_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .adc_sample (adc_sample),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_data     (q_wr_data),
        .q_full     (q_full)
    );

    irdal_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    irdal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    irdal_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rd_data),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .pop          (pop),
        .empty        (empty),
        .distance_cm  (distance_cm),
        .mean_value   (mean_value),
        .out_of_range (out_of_range)
    );
endmodule
`default_nettype wire
